// ===== hw/rtl/ebc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_pkg: shared types and constants for the 8-bit CPU subset execute unit
// Holds action codes, operation classes, the queue entry type and helpers.
// ----------------------------------------------------------------------------
package ebc_pkg;

    localparam int unsigned ADDRESS_BITS_DEFAULT = 16;
    localparam logic [7:0] STOP_OPCODE = 8'hEF;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [2:0] OPND_MEM = 3'd6;

    typedef enum logic [1:0] {
        ACT_EXEC  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_PRESET = 2'd3
    } action_t;

    // operation classes produced by the front decoder
    typedef enum logic [3:0] {
        OP_NOP,
        OP_STOP,
        OP_LXI,
        OP_INX,
        OP_DCX,
        OP_INR,
        OP_DCR,
        OP_MVI,
        OP_CMC,
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_MEMWR,
        OP_MEMRD,
        OP_PRESET
    } op_class_t;

    // decoded transaction handed from front to back
    typedef struct packed {
        op_class_t  op;
        logic [2:0] dst;      // register file index
        logic [2:0] src;      // register file index
        logic       dst_mem;  // destination is the memory byte at HL
        logic       src_mem;  // source is the memory byte at HL
        logic [7:0] lo;
        logic [7:0] hi;
        logic [15:0] addr;
    } dec_t;

    // operand code (B,C,D,E,H,L,M,A) to register file index (A=0..L=6)
    function automatic logic [2:0] code_index(input logic [2:0] code);
        logic [2:0] r;
        begin
            case (code)
                3'd7:     r = 3'd0;
                OPND_MEM: r = 3'd0;
                default:  r = code + 3'd1;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/eight_bit_cpu_subset_execute_top.sv =====
`timescale 1ns / 1ps
// Path: each input passes the queue, then the memory read, then execute into the result register.
// Throughput: one transaction per cycle unless a held result stalls; the memory read is issued on acceptance
// into the execute stage and the result is registered in the same step as writeback.
// A held result stalls the back end; the two-entry queue then fills and drops tready.
// Reset (rst_n, async low) clears registers, flags and queue; memory is not cleared.
// ----------------------------------------------------------------------------
// eight_bit_cpu_subset_execute_top: 8085 subset execute unit
// Front decoder, two-entry queue and execute back end with data memory.
// ----------------------------------------------------------------------------
module eight_bit_cpu_subset_execute_top
    import ebc_pkg::*;
#(
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], opcode[9:2], data_low[17:10], data_high[25:18], address[41:26]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], reg_a[15:8], reg_b[23:16], reg_c[31:24], reg_d[39:32],
    // reg_e[47:40], reg_h[55:48], reg_l[63:56], flag_byte[71:64], stopped[72]
    output logic [79:0] m_axis_tdata
);

    dec_t       dec;
    dec_t       q_data;
    logic       q_valid;
    logic       q_ready;
    logic [72:0] res;

    ebc_front u_front (
        .action   (s_axis_tdata[1:0]),
        .opcode   (s_axis_tdata[9:2]),
        .data_low (s_axis_tdata[17:10]),
        .data_high(s_axis_tdata[25:18]),
        .address  (s_axis_tdata[41:26]),
        .dec      (dec)
    );

    ebc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (dec),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    ebc_back #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (res)
    );

    assign m_axis_tdata = {7'd0, res};

endmodule

// ===== hw/rtl/ebc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_front: accept and classify transactions
// Decodes each input transaction into an operation class and operand codes.
// ----------------------------------------------------------------------------
module ebc_front
    import ebc_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [7:0]  opcode,
    input  logic [7:0]  data_low,
    input  logic [7:0]  data_high,
    input  logic [15:0] address,
    output dec_t        dec
);

    logic [2:0] dst_code;
    logic [2:0] src_code;
    logic [1:0] pair;

    assign dst_code = opcode[5:3];
    assign src_code = opcode[2:0];
    assign pair     = opcode[5:4];

    // classify the transaction
    always_comb
    begin
        dec.op      = OP_NOP;
        dec.dst     = code_index(dst_code);
        dec.src     = code_index(src_code);
        dec.dst_mem = (dst_code == OPND_MEM);
        dec.src_mem = (src_code == OPND_MEM);
        dec.lo      = data_low;
        dec.hi      = data_high;
        dec.addr    = address;
        case (action_t'(action))
            ACT_WRITE: dec.op = OP_MEMWR;
            ACT_READ:  dec.op = OP_MEMRD;
            ACT_PRESET:
            begin
                if (address < 16'd7)
                begin
                    dec.op      = OP_PRESET;
                    dec.dst     = address[2:0];
                    dec.dst_mem = 1'b0;
                end
            end
            default:
            begin
                if (opcode == STOP_OPCODE)
                    dec.op = OP_STOP;
                else if (opcode[7:6] == 2'b00)
                begin
                    // register pair index for LXI/INX/DCX: B=1, D=3, H=5
                    if (pair != 2'd3 && opcode[3:0] == 4'h1)
                    begin
                        dec.op = OP_LXI;
                        dec.dst = {pair, 1'b1};
                    end
                    else if (pair != 2'd3 && opcode[3:0] == 4'h3)
                    begin
                        dec.op = OP_INX;
                        dec.dst = {pair, 1'b1};
                    end
                    else if (pair != 2'd3 && opcode[3:0] == 4'hB)
                    begin
                        dec.op = OP_DCX;
                        dec.dst = {pair, 1'b1};
                    end
                    else if (src_code == 3'd4)
                        dec.op = OP_INR;
                    else if (src_code == 3'd5)
                        dec.op = OP_DCR;
                    else if (src_code == 3'd6)
                        dec.op = OP_MVI;
                    else if (opcode == 8'h3F)
                        dec.op = OP_CMC;
                end
                else if (opcode[7:6] == 2'b01)
                begin
                    if (opcode != 8'h76)
                        dec.op = OP_MOV;
                end
                else if (opcode[7:3] == 5'b10000)
                    dec.op = OP_ADD;
                else if (opcode[7:3] == 5'b10010)
                    dec.op = OP_SUB;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ebc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_fifo: two-entry queue between front and back
// Decouples decode from execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module ebc_fifo
    import ebc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  dec_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output dec_t out_data
);

    dec_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_pop_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == 2'd1) |=> !out_valid)
        else $error("queue not empty after last pop");
    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && count_reg == 2'd1) |=> !in_ready)
        else $error("queue not full after second push");
`endif

endmodule

// ===== hw/rtl/ebc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_back: execute decoded transactions
// Holds registers, flags and the data memory; each transaction passes through
// a memory read, then execute, writeback and result register load.
// ----------------------------------------------------------------------------
module ebc_back
    import ebc_pkg::*;
#(
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dec_t       in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [72:0] out_data
);

    localparam int unsigned DEPTH = 1 << ADDRESS_BITS;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rf_reg [7];
    logic [7:0]  rf_next [7];
    logic [4:0]  flag_reg;       // {S,Z,AC,P,CY}
    logic [4:0]  flag_next;
    logic        busy_reg;
    dec_t        cur_reg;
    logic [7:0]  rdata_reg;
    logic        oval_reg;
    logic [72:0] odata_reg;
    logic [72:0] odata_next;
    logic [ADDRESS_BITS-1:0] rd_addr;
    logic [ADDRESS_BITS-1:0] hl_addr;
    logic [ADDRESS_BITS-1:0] hl_next;
    logic        mem_we;
    logic [ADDRESS_BITS-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic        take;
    logic        finish;
    logic [7:0]  opnd;
    logic [7:0]  alu_b;
    logic        alu_cin;
    logic [8:0]  sum;
    logic [4:0]  half;
    logic [7:0]  res;
    logic [15:0] pair_val;
    logic [15:0] pair_new;
    logic [7:0]  read_data;
    logic        stopped;
    logic [7:0]  flag_byte;

    assign take     = in_valid && in_ready;
    assign finish   = busy_reg && (!oval_reg || out_ready);
    assign in_ready = !busy_reg || finish;
    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

    // HL now and after the transaction being finished this cycle
    assign hl_addr = ADDRESS_BITS'({rf_reg[5], rf_reg[6]});
    assign hl_next = ADDRESS_BITS'({rf_next[5], rf_next[6]});

    // pick the memory read address: the given address for memory reads, else HL
    always_comb
    begin
        if (in_data.op == OP_MEMRD)
            rd_addr = in_data.addr[ADDRESS_BITS-1:0];
        else
            rd_addr = take && busy_reg ? hl_next : hl_addr;
    end

    // read memory on acceptance; forward a write landing in the same cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (mem_we && wr_addr == rd_addr)
                rdata_reg <= wr_data;
            else
                rdata_reg <= mem[rd_addr];
        end
        if (mem_we)
            mem[wr_addr] <= wr_data;
    end

    // hold the transaction being executed
    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= in_data;
    end

    // operand and ALU
    always_comb
    begin
        case (cur_reg.op)
            OP_INR, OP_DCR:
                opnd = cur_reg.dst_mem ? rdata_reg : rf_reg[cur_reg.dst];
            default:
                opnd = cur_reg.src_mem ? rdata_reg : rf_reg[cur_reg.src];
        endcase
        alu_b   = 8'h01;
        alu_cin = 1'b0;
        case (cur_reg.op)
            OP_DCR: alu_b = 8'hFF;
            OP_ADD: alu_b = opnd;
            OP_SUB:
            begin
                alu_b   = ~opnd;
                alu_cin = 1'b1;
            end
            default: alu_b = 8'h01;
        endcase
    end

    assign sum  = (cur_reg.op == OP_ADD || cur_reg.op == OP_SUB)
                ? {1'b0, rf_reg[0]} + {1'b0, alu_b} + {8'd0, alu_cin}
                : {1'b0, opnd} + {1'b0, alu_b};
    assign half = (cur_reg.op == OP_ADD || cur_reg.op == OP_SUB)
                ? {1'b0, rf_reg[0][3:0]} + {1'b0, alu_b[3:0]} + {4'd0, alu_cin}
                : {1'b0, opnd[3:0]} + {1'b0, alu_b[3:0]};
    assign res  = sum[7:0];
    assign pair_val = {rf_reg[cur_reg.dst], rf_reg[cur_reg.dst + 3'd1]};
    assign pair_new = (cur_reg.op == OP_INX) ? pair_val + 16'd1 : pair_val - 16'd1;

    // next architectural state, memory write and result
    always_comb
    begin
        for (int i = 0; i < 7; i++)
            rf_next[i] = rf_reg[i];
        flag_next = flag_reg;
        mem_we    = 1'b0;
        wr_addr   = hl_addr;
        wr_data   = cur_reg.lo;
        read_data = ZERO_BYTE;
        stopped   = 1'b0;
        case (cur_reg.op)
            OP_STOP: stopped = 1'b1;
            OP_LXI:
            begin
                rf_next[cur_reg.dst] = cur_reg.hi;
                rf_next[cur_reg.dst + 3'd1] = cur_reg.lo;
            end
            OP_INX, OP_DCX:
            begin
                rf_next[cur_reg.dst] = pair_new[15:8];
                rf_next[cur_reg.dst + 3'd1] = pair_new[7:0];
            end
            OP_INR, OP_DCR:
            begin
                flag_next = {res[7], res == 8'd0, half[4], ~^res, flag_reg[0]};
                if (cur_reg.dst_mem)
                begin
                    mem_we  = 1'b1;
                    wr_data = res;
                end
                else
                    rf_next[cur_reg.dst] = res;
            end
            OP_MVI, OP_MOV:
            begin
                wr_data = (cur_reg.op == OP_MVI) ? cur_reg.lo : opnd;
                if (cur_reg.dst_mem)
                    mem_we = 1'b1;
                else
                    rf_next[cur_reg.dst] = wr_data;
            end
            OP_CMC: flag_next[0] = ~flag_reg[0];
            OP_ADD, OP_SUB:
            begin
                rf_next[0] = res;
                flag_next = {res[7], res == 8'd0, half[4], ~^res,
                             (cur_reg.op == OP_ADD) ? sum[8] : ~sum[8]};
            end
            OP_MEMWR:
            begin
                mem_we  = 1'b1;
                wr_addr = cur_reg.addr[ADDRESS_BITS-1:0];
            end
            OP_MEMRD: read_data = rdata_reg;
            OP_PRESET: rf_next[cur_reg.dst] = cur_reg.lo;
            default: ;
        endcase
        mem_we = mem_we && finish;
        flag_byte = {flag_next[4], flag_next[3], 1'b0, flag_next[2], 1'b0,
                     flag_next[1], 1'b0, flag_next[0]};
        odata_next = {stopped, flag_byte, rf_next[6], rf_next[5], rf_next[4],
                      rf_next[3], rf_next[2], rf_next[1], rf_next[0], read_data};
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (finish)
            odata_reg <= odata_next;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
            flag_reg <= 5'd0;
            for (int i = 0; i < 7; i++)
                rf_reg[i] <= 8'd0;
        end
        else
        begin
            if (take)
                busy_reg <= 1'b1;
            else if (finish)
                busy_reg <= 1'b0;
            if (finish)
                oval_reg <= 1'b1;
            else if (out_ready)
                oval_reg <= 1'b0;
            if (finish)
            begin
                flag_reg <= flag_next;
                for (int i = 0; i < 7; i++)
                    rf_reg[i] <= rf_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !out_ready) |=> (oval_reg && $stable(odata_reg)))
        else $error("result changed while stalled");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> oval_reg) else $error("finished transaction lost");
    a_flag_gaps: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg |-> (odata_reg[69] == 1'b0 && odata_reg[67] == 1'b0
                      && odata_reg[65] == 1'b0))
        else $error("reserved flag bits set");
`endif

endmodule

// ===== test/tb_eight_bit_cpu_subset_execute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_subset_execute_top: self-checking bench for the execute unit
// Drives a directed table of instructions and memory/register actions, then
// random, mostly well-formed sequences, and compares each result transaction with a
// behavioral model of the register file, flags and memory kept in the bench.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_subset_execute_top
    import ebc_pkg::*;
();

    localparam int NUM_RANDOM = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    // flag bit positions inside the reported flag byte
    localparam int FB_S = 7;
    localparam int FB_Z = 6;
    localparam int FB_AC = 4;
    localparam int FB_P = 2;
    localparam int FB_CY = 0;

    // register file indexes
    localparam logic [2:0] IDX_A = 3'd0;
    localparam logic [2:0] IDX_H = 3'd5;
    localparam logic [2:0] IDX_L = 3'd6;

    // opcodes used by name in the directed table
    localparam logic [7:0] OPC_NOP = 8'h00;
    localparam logic [7:0] OPC_LXI_H = 8'h21;
    localparam logic [7:0] OPC_MVI_A = 8'h3E;
    localparam logic [7:0] OPC_MVI_M = 8'h36;
    localparam logic [7:0] OPC_INR_A = 8'h3C;
    localparam logic [7:0] OPC_DCR_A = 8'h3D;
    localparam logic [7:0] OPC_INR_M = 8'h34;
    localparam logic [7:0] OPC_DCR_M = 8'h35;
    localparam logic [7:0] OPC_INX_H = 8'h23;
    localparam logic [7:0] OPC_DCX_B = 8'h0B;
    localparam logic [7:0] OPC_ADD_A = 8'h87;
    localparam logic [7:0] OPC_ADD_M = 8'h86;
    localparam logic [7:0] OPC_SUB_B = 8'h90;
    localparam logic [7:0] OPC_SUB_M = 8'h96;
    localparam logic [7:0] OPC_MOV_BM = 8'h46;
    localparam logic [7:0] OPC_MOV_MA = 8'h77;
    localparam logic [7:0] OPC_MOV_AB = 8'h78;
    localparam logic [7:0] OPC_CMC = 8'h3F;
    localparam logic [7:0] OPC_HLT = 8'h76;
    localparam logic [7:0] OPC_JMP = 8'hC3;

    // last field in the lowest bits, as on s_axis_tdata
    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  data_high;
        logic [7:0]  data_low;
        logic [7:0]  opcode;
        logic [1:0]  action;
    } cmd_t;

    // last field in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic       stopped;
        logic [7:0] flag_byte;
        logic [7:0] reg_l, reg_h, reg_e, reg_d, reg_c, reg_b, reg_a;
        logic [7:0] read_data;
    } snap_t;

    typedef struct {
        cmd_t  cmd;
        logic  has_exp;
        snap_t exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    eight_bit_cpu_subset_execute_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // model state
    logic [7:0] mdl_regs [0:6];
    logic [7:0] mdl_flags;
    logic [7:0] mdl_mem [logic [15:0]];

    snap_t snap_queue [$];
    snap_t forced_queue [$];
    logic  forced_flag [$];
    int    mismatch_count;
    int    idle_cycles;
    bit    stim_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [2:0] opnd_index(input logic [2:0] code);
        return (code == 3'd7) ? IDX_A : code + 3'd1;
    endfunction

    function automatic logic [15:0] hl_ptr();
        return {mdl_regs[IDX_H], mdl_regs[IDX_L]};
    endfunction

    function automatic logic [7:0] get_opnd(input logic [2:0] code);
        if (code == OPND_MEM)
            return mdl_mem.exists(hl_ptr()) ? mdl_mem[hl_ptr()] : ZERO_BYTE;
        return mdl_regs[opnd_index(code)];
    endfunction

    function automatic void put_opnd(input logic [2:0] code, input logic [7:0] v);
        if (code == OPND_MEM)
            mdl_mem[hl_ptr()] = v;
        else
            mdl_regs[opnd_index(code)] = v;
    endfunction

    // sum with flag update; keep_cy leaves carry untouched
    function automatic logic [7:0] alu_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic cin, input logic keep_cy);
        logic [8:0] s;
        logic [4:0] half;
        logic [7:0] f;
        s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        f = '0;
        f[FB_S] = s[7];
        f[FB_Z] = (s[7:0] == 8'd0);
        f[FB_P] = ~^s[7:0];
        f[FB_AC] = half[4];
        f[FB_CY] = keep_cy ? mdl_flags[FB_CY] : s[8];
        mdl_flags = f;
        return s[7:0];
    endfunction

    function automatic void step_pair(input logic [2:0] hi, input logic up);
        logic [15:0] v;
        v = {mdl_regs[hi], mdl_regs[hi + 3'd1]};
        v = up ? v + 16'd1 : v - 16'd1;
        mdl_regs[hi] = v[15:8];
        mdl_regs[hi + 3'd1] = v[7:0];
    endfunction

    // apply one command to the model and return the expected result
    function automatic snap_t predict_state(input cmd_t c);
        snap_t r;
        logic [2:0] dst, src, hi;
        logic [7:0] v, a;
        dst = c.opcode[5:3];
        src = c.opcode[2:0];
        hi = 3'd1 + 3'd2 * c.opcode[5:4];
        r = '0;
        case (action_t'(c.action))
            ACT_EXEC:
            begin
                if (c.opcode == STOP_OPCODE)
                    r.stopped = 1'b1;
                else if (c.opcode < 8'h40)
                begin
                    if (c.opcode[7:6] == 2'b00 && c.opcode[5:4] != 2'b11 &&
                        c.opcode[3:0] == 4'h1)
                    begin
                        mdl_regs[hi] = c.data_high;
                        mdl_regs[hi + 3'd1] = c.data_low;
                    end
                    else if (c.opcode[5:4] != 2'b11 && c.opcode[3:0] == 4'h3)
                        step_pair(hi, 1'b1);
                    else if (c.opcode[5:4] != 2'b11 && c.opcode[3:0] == 4'hB)
                        step_pair(hi, 1'b0);
                    else if (src == 3'd4)
                        put_opnd(dst, alu_sum(get_opnd(dst), 8'h01, 1'b0, 1'b1));
                    else if (src == 3'd5)
                        put_opnd(dst, alu_sum(get_opnd(dst), 8'hFF, 1'b0, 1'b1));
                    else if (src == 3'd6)
                        put_opnd(dst, c.data_low);
                    else if (c.opcode == OPC_CMC)
                        mdl_flags[FB_CY] = ~mdl_flags[FB_CY];
                end
                else if (c.opcode < 8'h80)
                begin
                    if (c.opcode != OPC_HLT)
                        put_opnd(dst, get_opnd(src));
                end
                else if (c.opcode < 8'h88)
                    mdl_regs[IDX_A] = alu_sum(mdl_regs[IDX_A], get_opnd(src), 1'b0, 1'b0);
                else if (c.opcode >= 8'h90 && c.opcode < 8'h98)
                begin
                    v = get_opnd(src);
                    a = mdl_regs[IDX_A];
                    mdl_regs[IDX_A] = alu_sum(a, ~v, 1'b1, 1'b0);
                    mdl_flags[FB_CY] = (a < v);
                end
            end
            ACT_WRITE: mdl_mem[c.address] = c.data_low;
            ACT_READ: r.read_data = mdl_mem.exists(c.address) ? mdl_mem[c.address] : ZERO_BYTE;
            default:
            begin
                if (c.address < 16'd7)
                    mdl_regs[c.address[2:0]] = c.data_low;
            end
        endcase
        r.reg_a = mdl_regs[0]; r.reg_b = mdl_regs[1]; r.reg_c = mdl_regs[2];
        r.reg_d = mdl_regs[3]; r.reg_e = mdl_regs[4]; r.reg_h = mdl_regs[5];
        r.reg_l = mdl_regs[6]; r.flag_byte = mdl_flags;
        return r;
    endfunction

    // true when the command would read memory that was never written
    function automatic bit reads_unwritten(input cmd_t c);
        logic [7:0] op;
        op = c.opcode;
        if (c.action == ACT_READ)
            return !mdl_mem.exists(c.address);
        if (c.action != ACT_EXEC)
            return 1'b0;
        if ((op < 8'h40 && (op[2:0] == 3'd4 || op[2:0] == 3'd5) && op[5:3] == OPND_MEM) ||
            (op >= 8'h40 && op < 8'h80 && op != OPC_HLT && op[2:0] == OPND_MEM) ||
            ((op < 8'h88 || (op >= 8'h90 && op < 8'h98)) && op >= 8'h80 &&
             op[2:0] == OPND_MEM))
            return !mdl_mem.exists(hl_ptr());
        return 1'b0;
    endfunction

    function automatic cmd_t mk(input action_t act, input logic [7:0] op,
                                input logic [7:0] lo, input logic [7:0] hi,
                                input logic [15:0] addr);
        cmd_t c;
        c.action = act; c.opcode = op; c.data_low = lo; c.data_high = hi; c.address = addr;
        return c;
    endfunction

    // idle the input for a random number of cycles
    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // drive one transaction and wait for acceptance
    task automatic send_cmd(input cmd_t c, input logic has_exp, input snap_t exp);
        snap_t p;
        p = predict_state(c);
        snap_queue = {snap_queue, p};
        forced_flag = {forced_flag, has_exp};
        forced_queue = {forced_queue, exp};
        s_axis_tdata <= {6'd0, c};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random command, mostly well formed
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int k;
        c = mk(ACT_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        k = $urandom_range(0, 19);
        if (k < 2)
            c.action = ACT_WRITE;
        else if (k < 3)
            c.action = ACT_PRESET;
        else if (k < 4)
        begin
            c.action = ACT_WRITE;
            c.address = hl_ptr();
        end
        else if (k < 5)
            c.action = ACT_READ;
        else if (k < 6)
            c.address[15:3] = '0;
        if (c.action == ACT_PRESET && $urandom_range(0, 3) != 0)
            c.address = 16'($urandom_range(0, 7));
        if (c.action == ACT_READ && !mdl_mem.exists(c.address))
            c.action = ACT_WRITE;
        if (reads_unwritten(c))
            c = mk(ACT_WRITE, OPC_NOP, 8'($urandom_range(0, 255)), 8'h00, hl_ptr());
        return c;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        snap_t got, want;
        logic  typed;
        snap_t fexp;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[72:0];
            if (snap_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %h", got);
            end
            else
            begin
                want = snap_queue.pop_front();
                typed = forced_flag.pop_front();
                fexp = forced_queue.pop_front();
                if (got !== want || (typed && got !== fexp))
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %h (typed %h), got %h",
                                 want, fexp, got);
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (stim_done && snap_queue.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        row_t  rows [$];
        row_t  rw;
        snap_t z;
        snap_t e;
        int    i;
        z = '0;
        for (i = 0; i < 7; i++)
            mdl_regs[i] = 8'h00;
        mdl_flags = 8'h00;
        stim_done = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; typed result where plain to read
        rw.has_exp = 1'b1; rw.exp = z;
        rw.cmd = mk(ACT_EXEC, OPC_NOP, 8'h00, 8'h00, 16'h0000); rows = {rows, rw};
        e = z; e.stopped = 1'b1;
        rw.exp = e; rw.cmd = mk(ACT_EXEC, STOP_OPCODE, 8'hFF, 8'hFF, 16'hFFFF);
        rows = {rows, rw};
        e = z; e.reg_a = 8'hFF;
        rw.exp = e; rw.cmd = mk(ACT_PRESET, OPC_NOP, 8'hFF, 8'h00, 16'd0); rows = {rows, rw};
        rw.exp = e; rw.cmd = mk(ACT_PRESET, OPC_NOP, 8'h55, 8'h00, 16'd7); rows = {rows, rw};
        rw.exp = e; rw.cmd = mk(ACT_PRESET, OPC_NOP, 8'h55, 8'h00, 16'hFFFF);
        rows = {rows, rw};
        e.reg_a = 8'h00; e.flag_byte = 8'h54;
        rw.exp = e; rw.cmd = mk(ACT_EXEC, OPC_INR_A, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.has_exp = 1'b0;
        rw.cmd = mk(ACT_EXEC, OPC_DCR_A, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_LXI_H, 8'hFF, 8'hFF, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_MVI_M, 8'h80, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_INX_H, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_WRITE, OPC_NOP, 8'hFF, 8'h00, 16'h0000); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_INR_M, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_DCR_M, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_DCX_B, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_MVI_A, 8'h7F, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_ADD_A, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_ADD_M, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_SUB_B, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_SUB_M, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_MOV_BM, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_MOV_MA, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_MOV_AB, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_CMC, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_HLT, 8'h00, 8'h00, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_EXEC, OPC_JMP, 8'h12, 8'h34, 16'd0); rows = {rows, rw};
        rw.cmd = mk(ACT_READ, OPC_NOP, 8'h00, 8'h00, 16'h0000); rows = {rows, rw};

        foreach (rows[k])
        begin
            random_gap();
            send_cmd(rows[k].cmd, rows[k].has_exp, rows[k].exp);
        end

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            random_gap();
            send_cmd(rand_cmd(), 1'b0, z);
        end

        // drop valid after the last transaction
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (snap_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ebc_pkg.sv
hw/rtl/ebc_front.sv
hw/rtl/ebc_fifo.sv
hw/rtl/ebc_back.sv
hw/rtl/eight_bit_cpu_subset_execute_top.sv
test/tb_eight_bit_cpu_subset_execute_top.sv
